/* rtl/core/ata_pkg.sv */
package ata_pkg;

  localparam int CORDIC_STEPS = 25;
  localparam int ANG_W        = 28;
  localparam int ANG_FRAC     = 12;
  localparam int OUT_W        = 15;
  localparam int MAG_W        = 14;
  localparam logic [MAG_W-1:0] FULL_TILT = MAG_W'(9000);

  typedef struct packed {
    logic xneg;
    logic xzero;
    logic szero;
  } side_t;

  // atan(2^-i) in degrees, scaled by 409600
  function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
    logic signed [ANG_W-1:0] v;
    begin
      case (idx)
        0: v = ANG_W'(18432000);
        1: v = ANG_W'(10881045);
        2: v = ANG_W'(5749245);
        3: v = ANG_W'(2918407);
        4: v = ANG_W'(1464867);
        5: v = ANG_W'(733147);
        6: v = ANG_W'(366663);
        7: v = ANG_W'(183343);
        8: v = ANG_W'(91673);
        9: v = ANG_W'(45837);
        10: v = ANG_W'(22918);
        11: v = ANG_W'(11459);
        12: v = ANG_W'(5730);
        13: v = ANG_W'(2865);
        14: v = ANG_W'(1432);
        15: v = ANG_W'(716);
        16: v = ANG_W'(358);
        17: v = ANG_W'(179);
        18: v = ANG_W'(90);
        19: v = ANG_W'(45);
        20: v = ANG_W'(22);
        21: v = ANG_W'(11);
        22: v = ANG_W'(6);
        23: v = ANG_W'(3);
        24: v = ANG_W'(1);
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

/* rtl/core/ata_in_if.sv */
interface ata_in_if #(
  parameter int AXIS_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [AXIS_WIDTH-1:0] accel_x;
  logic signed [AXIS_WIDTH-1:0] accel_y;
  logic signed [AXIS_WIDTH-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

/* rtl/core/ata_out_if.sv */
interface ata_out_if ();
  logic                              valid;
  logic                              ready;
  logic signed [ata_pkg::OUT_W-1:0]  tilt_centideg;

  modport source (output valid, output tilt_centideg, input ready);
  modport sink (input valid, input tilt_centideg, output ready);
endinterface

/* rtl/core/ata_isqrt.sv */
module ata_isqrt #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [2*AXIS_WIDTH:0]        in_sum,
  input  logic [AXIS_WIDTH-1:0]        in_ax,
  input  ata_pkg::side_t               in_side,
  output logic                         out_valid,
  output logic [AXIS_WIDTH+8:0]        out_root,
  output logic [AXIS_WIDTH-1:0]        out_ax,
  output ata_pkg::side_t               out_side
);

  localparam int N  = 2*AXIS_WIDTH + 18;
  localparam int Q  = N / 2;
  localparam int RW = Q + 3;

  logic                  vld_r  [Q+1];
  logic [RW-1:0]         rem_r  [Q+1];
  logic [Q-1:0]          root_r [Q+1];
  logic [N-1:0]          rad_r  [Q+1];
  logic [AXIS_WIDTH-1:0] ax_r   [Q+1];
  ata_pkg::side_t        side_r [Q+1];

  // radicand is sum * 65536, padded to an even bit count with a leading zero
  always_comb begin
    vld_r[0]  = in_valid;
    rem_r[0]  = '0;
    root_r[0] = '0;
    rad_r[0]  = {1'b0, in_sum, 16'd0};
    ax_r[0]   = in_ax;
    side_r[0] = in_side;
  end

  // one root bit per stage
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [RW-1:0] cat;
    logic [RW-1:0] trial;
    logic          fits;
    logic [RW-1:0] rem_nxt;
    logic [Q-1:0]  root_nxt;

    always_comb begin
      cat      = {rem_r[k][RW-3:0], rad_r[k][N-1:N-2]};
      trial    = RW'({root_r[k], 2'b01});
      fits     = cat >= trial;
      rem_nxt  = fits ? (cat - trial) : cat;
      root_nxt = {root_r[k][Q-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (ce) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (ce) begin
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        rad_r[k+1]  <= {rad_r[k][N-3:0], 2'b00};
        ax_r[k+1]   <= ax_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[Q];
  assign out_root  = root_r[Q];
  assign out_ax    = ax_r[Q];
  assign out_side  = side_r[Q];

endmodule

/* rtl/core/ata_cordic.sv */
module ata_cordic #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ce,
  input  logic                               in_valid,
  input  logic [AXIS_WIDTH+8:0]              in_root,
  input  logic [AXIS_WIDTH-1:0]              in_ax,
  input  ata_pkg::side_t                     in_side,
  output logic                               out_valid,
  output logic signed [ata_pkg::ANG_W-1:0]   out_ang,
  output ata_pkg::side_t                     out_side
);

  localparam int CW = AXIS_WIDTH + 11;
  localparam int S  = ata_pkg::CORDIC_STEPS;

  logic                             vld_r  [S+1];
  logic signed [CW-1:0]             cx_r   [S+1];
  logic signed [CW-1:0]             cy_r   [S+1];
  logic signed [ata_pkg::ANG_W-1:0] cz_r   [S+1];
  ata_pkg::side_t                   side_r [S+1];

  always_comb begin
    vld_r[0]  = in_valid;
    cx_r[0]   = signed'(CW'(in_root));
    cy_r[0]   = signed'(CW'({in_ax, 8'd0}));
    cz_r[0]   = '0;
    side_r[0] = in_side;
  end

  // vectoring mode: drive y toward zero, accumulate the angle
  for (genvar i = 0; i < S; i++) begin : g_step
    localparam logic signed [ata_pkg::ANG_W-1:0] ANG = ata_pkg::atan_step(i);
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb begin
      dx = cy_r[i] >>> i;
      dy = cx_r[i] >>> i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (ce) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (ce) begin
        if (!cy_r[i][CW-1]) begin
          cx_r[i+1] <= cx_r[i] + dx;
          cy_r[i+1] <= cy_r[i] - dy;
          cz_r[i+1] <= cz_r[i] + ANG;
        end else begin
          cx_r[i+1] <= cx_r[i] - dx;
          cy_r[i+1] <= cy_r[i] + dy;
          cz_r[i+1] <= cz_r[i] - ANG;
        end
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_valid = vld_r[S];
  assign out_ang   = cz_r[S];
  assign out_side  = side_r[S];

endmodule

/* rtl/core/accel_tilt_angle.sv */
// tilt angle of the x axis from one three-axis accelerometer sample
//
// in_ch carries signed accel_x, accel_y, accel_z (milli-g); out_ch returns
// tilt_centideg = atan2(x, |(y,z)|) in 0.01 degree, within -9000..9000.
// both channels use valid/ready; a request moves when both are high.
// every sample gives exactly one result, in order.
// pipeline from accepted sample to out_ch.valid: abs and squares, sum, one
// stage per root bit of the integer square root, 25 cordic stages, rounding,
// sign and output reg.
// throughput: one sample per cycle while the pipeline is not frozen; the whole
// pipeline is one stage wide per step, so a new sample can enter every clock.
// when the receiver holds out_ch.ready low with a result pending, the
// pipeline freezes and in_ch.ready drops; nothing is lost or repeated and
// the pending result stays on out_ch until taken.
// reset (rst_n low, synchronous) clears all valid bits; no sample is in
// flight afterwards and in_ch.ready is high.
module accel_tilt_angle #(
  parameter int AXIS_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ata_in_if.sink    in_ch,
  ata_out_if.source out_ch
);

  localparam int W  = AXIS_WIDTH;
  localparam int SW = ata_pkg::ANG_W - ata_pkg::ANG_FRAC;

  logic ce;
  logic out_valid_r;
  logic signed [ata_pkg::OUT_W-1:0] out_tilt_r;

  assign ce          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = ce;

  // stage 0: magnitudes
  logic                  s0_valid_r;
  logic [W-1:0]          s0_ax_r, s0_ay_r, s0_az_r;
  ata_pkg::side_t        s0_side_r;

  // stage 1: squares
  logic                  s1_valid_r;
  logic [2*W-1:0]        s1_ysq_r, s1_zsq_r;
  logic [W-1:0]          s1_ax_r;
  ata_pkg::side_t        s1_side_r;

  // stage 2: sum of squares
  logic                  s2_valid_r;
  logic [2*W:0]          s2_sum_r;
  logic [W-1:0]          s2_ax_r;
  ata_pkg::side_t        s2_side_r;

  logic [2*W:0]          sum_nxt;

  always_comb begin
    sum_nxt = (2*W+1)'(s1_ysq_r) + (2*W+1)'(s1_zsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (ce) begin
      s0_valid_r <= in_ch.valid;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
    if (ce) begin
      s0_ax_r         <= in_ch.accel_x[W-1] ? W'(-in_ch.accel_x) : W'(in_ch.accel_x);
      s0_ay_r         <= in_ch.accel_y[W-1] ? W'(-in_ch.accel_y) : W'(in_ch.accel_y);
      s0_az_r         <= in_ch.accel_z[W-1] ? W'(-in_ch.accel_z) : W'(in_ch.accel_z);
      s0_side_r.xneg  <= in_ch.accel_x[W-1];
      s0_side_r.xzero <= in_ch.accel_x == '0;
      s0_side_r.szero <= 1'b0;

      s1_ysq_r  <= (2*W)'(s0_ay_r) * (2*W)'(s0_ay_r);
      s1_zsq_r  <= (2*W)'(s0_az_r) * (2*W)'(s0_az_r);
      s1_ax_r   <= s0_ax_r;
      s1_side_r <= s0_side_r;

      s2_sum_r        <= sum_nxt;
      s2_ax_r         <= s1_ax_r;
      s2_side_r.xneg  <= s1_side_r.xneg;
      s2_side_r.xzero <= s1_side_r.xzero;
      s2_side_r.szero <= sum_nxt == '0;
    end
  end

  logic           sq_valid;
  logic [W+8:0]   sq_root;
  logic [W-1:0]   sq_ax;
  ata_pkg::side_t sq_side;

  ata_isqrt #(.AXIS_WIDTH(W)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (s2_valid_r),
    .in_sum    (s2_sum_r),
    .in_ax     (s2_ax_r),
    .in_side   (s2_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_ax    (sq_ax),
    .out_side  (sq_side)
  );

  logic                             cd_valid;
  logic signed [ata_pkg::ANG_W-1:0] cd_ang;
  ata_pkg::side_t                   cd_side;

  ata_cordic #(.AXIS_WIDTH(W)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_ax     (sq_ax),
    .in_side   (sq_side),
    .out_valid (cd_valid),
    .out_ang   (cd_ang),
    .out_side  (cd_side)
  );

  // round to centidegrees, ties upward, then clamp to 0..9000
  logic                             rd_valid_r;
  logic [ata_pkg::MAG_W-1:0]        rd_mag_r;
  ata_pkg::side_t                   rd_side_r;
  logic signed [ata_pkg::ANG_W-1:0] ang_bias;
  logic signed [SW-1:0]             ang_cd;
  logic [ata_pkg::MAG_W-1:0]        mag_nxt;

  always_comb begin
    ang_bias = cd_ang + ata_pkg::ANG_W'(1 << (ata_pkg::ANG_FRAC - 1));
    ang_cd   = ang_bias[ata_pkg::ANG_W-1:ata_pkg::ANG_FRAC];
    if (ang_cd[SW-1]) begin
      mag_nxt = '0;
    end else if (ang_cd > signed'(SW'(ata_pkg::FULL_TILT))) begin
      mag_nxt = ata_pkg::FULL_TILT;
    end else begin
      mag_nxt = ata_pkg::MAG_W'(ang_cd);
    end
  end

  logic [ata_pkg::MAG_W-1:0]        mag_sel;
  logic signed [ata_pkg::OUT_W-1:0] tilt_nxt;

  always_comb begin
    if (rd_side_r.xzero) begin
      mag_sel = '0;
    end else if (rd_side_r.szero) begin
      mag_sel = ata_pkg::FULL_TILT;
    end else begin
      mag_sel = rd_mag_r;
    end
    tilt_nxt = rd_side_r.xneg ? -signed'(ata_pkg::OUT_W'(mag_sel))
                              : signed'(ata_pkg::OUT_W'(mag_sel));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      rd_valid_r  <= cd_valid;
      out_valid_r <= rd_valid_r;
    end
    if (ce) begin
      rd_mag_r   <= mag_nxt;
      rd_side_r  <= cd_side;
      out_tilt_r <= tilt_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.tilt_centideg = out_tilt_r;

endmodule
